@@ src/bcn_tbd_pkg.sv @@
// Shared types, constants and texel arithmetic for the BC1..BC5 block decoder.
// No dependencies; imported by bcn_texture_block_decode and tb_top.
package bcn_tbd_pkg;

  // Largest image edge honoured by clipping; wider settings saturate to it.
  localparam int unsigned MaxImageSize = 16384;
  // Width of the clip compare: block origin plus column offset, and the limit.
  localparam int ClipW = 17;

  // Format codes held in the format register.
  localparam logic [2:0] FmtBc1 = 3'd1;
  localparam logic [2:0] FmtBc2 = 3'd2;
  localparam logic [2:0] FmtBc3 = 3'd3;
  localparam logic [2:0] FmtBc4 = 3'd4;
  localparam logic [2:0] FmtBc5 = 3'd5;

  // Byte write masks.
  localparam logic [3:0] MaskRgba = 4'hF;
  localparam logic [3:0] MaskR    = 4'h1;
  localparam logic [3:0] MaskRg   = 4'h3;
  localparam logic [3:0] MaskNone = 4'h0;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgFormat  = 2'd0,
    CfgNoAlpha = 2'd1,
    CfgWidth   = 2'd2,
    CfgHeight  = 2'd3
  } cfg_reg_e;

  // Divisor applied in the second stage.
  typedef enum logic [1:0] {
    DivNone = 2'd0,
    Div3    = 2'd1,
    Div5    = 2'd2,
    Div7    = 2'd3
  } div_e;

  // One output byte before division: sign, magnitude and divisor.
  typedef struct packed {
    logic       neg;
    logic [10:0] mag;
    div_e       div;
  } num_t;

  typedef num_t [3:0] px_t;

  function automatic num_t num_direct(logic [7:0] v);
    num_t n;
    n.neg = 1'b0;
    n.mag = 11'(v);
    n.div = DivNone;
    return n;
  endfunction

  function automatic logic [2:0][7:0] expand565(logic [15:0] v);
    logic [2:0][7:0] r;
    r[0] = {v[4:0], v[4:2]};
    r[1] = {v[10:5], v[10:9]};
    r[2] = {v[15:11], v[15:13]};
    return r;
  endfunction

  // Colour texel k of a 64-bit colour half: bytes 0..2 colour, byte 3 alpha.
  function automatic px_t color_texel(logic [63:0] word, logic [3:0] k, logic four,
                                      logic transparent);
    logic [15:0]     e0;
    logic [15:0]     e1;
    logic [1:0]      sel;
    logic [2:0][7:0] a;
    logic [2:0][7:0] b;
    logic            four_like;
    px_t             px;
    e0        = word[15:0];
    e1        = word[31:16];
    sel       = 2'(word[63:32] >> {k, 1'b0});
    a         = expand565(e0);
    b         = expand565(e1);
    four_like = four || (e0 > e1);
    for (int n = 0; n < 3; n++) begin
      case (sel)
        2'd0: px[n] = num_direct(a[n]);
        2'd1: px[n] = num_direct(b[n]);
        2'd2: begin
          if (four_like) begin
            px[n] = '{neg: 1'b0, mag: 11'({a[n], 1'b0}) + 11'(b[n]), div: Div3};
          end else begin
            px[n] = num_direct(8'((9'(a[n]) + 9'(b[n])) >> 1));
          end
        end
        default: begin
          if (four_like) begin
            px[n] = '{neg: 1'b0, mag: 11'({b[n], 1'b0}) + 11'(a[n]), div: Div3};
          end else begin
            px[n] = num_direct(8'd0);
          end
        end
      endcase
    end
    px[3] = num_direct((!four_like && sel == 2'd3 && transparent) ? 8'd0 : 8'd255);
    return px;
  endfunction

  // Interpolated single channel texel k; sgn treats the endpoints as signed.
  function automatic num_t chan_texel(logic [63:0] word, logic [3:0] k, logic sgn);
    logic signed [9:0]  sa;
    logic signed [9:0]  sb;
    logic [2:0]         sel;
    logic signed [4:0]  wa;
    logic signed [4:0]  wb;
    logic signed [11:0] sum;
    num_t               n;
    sa  = {{2{sgn & word[7]}}, word[7:0]};
    sb  = {{2{sgn & word[15]}}, word[15:8]};
    sel = 3'(word[63:16] >> (6'(k) * 6'd3));
    wa  = '0;
    wb  = '0;
    n.div = DivNone;
    if (sel == 3'd0) begin
      sum = 12'(sa);
    end else if (sel == 3'd1) begin
      sum = 12'(sb);
    end else if (sa > sb) begin
      wa    = 5'(5'd8 - {2'b00, sel});
      wb    = 5'({2'b00, sel} - 5'd1);
      sum   = 12'(wa) * 12'(sa) + 12'(wb) * 12'(sb);
      n.div = Div7;
    end else if (sel < 3'd6) begin
      wa    = 5'(5'd6 - {2'b00, sel});
      wb    = 5'({2'b00, sel} - 5'd1);
      sum   = 12'(wa) * 12'(sa) + 12'(wb) * 12'(sb);
      n.div = Div5;
    end else if (sel == 3'd6) begin
      sum = sgn ? -12'sd128 : 12'sd0;
    end else begin
      sum = sgn ? 12'sd127 : 12'sd255;
    end
    n.neg = sum[11];
    n.mag = sum[11] ? 11'(-sum) : 11'(sum);
    return n;
  endfunction

  // Divide by a constant through a reciprocal, then restore the sign.
  function automatic logic [7:0] div_out(num_t n);
    logic [23:0] p;
    logic [7:0]  q;
    p = '0;
    case (n.div)
      Div3: begin
        p = 24'(n.mag) * 24'd683;
        q = p[18:11];
      end
      Div5: begin
        p = 24'(n.mag) * 24'd3277;
        q = p[21:14];
      end
      Div7: begin
        p = 24'(n.mag) * 24'd2341;
        q = p[21:14];
      end
      default: q = n.mag[7:0];
    endcase
    return n.neg ? (~q) + 8'd1 : q;
  endfunction

endpackage

@@ src/bcn_texture_block_decode.sv @@
// BC1..BC5 compressed 4x4 block decoder: one texel result per cycle.
// Depends on bcn_tbd_pkg for codes, types and the texel arithmetic.
//
//  port group          direction  handshake                      beat
//  ------------------  ---------  -----------------------------  --------------------------
//  cfg_*               in         cfg_we_i, no wait              one register write
//  start/busy, block_* in         taken when start & !busy       one compressed block
//  texel_*, out_*, ... out        texel_strobe_o, one cycle      one texel, last_o on final
//
//  A block gives one beat per texel that lies inside the image (columns times rows
//  after clipping, 1 to 16), as the texel walker sets it. A wholly clipped block or
//  a bad format gives one empty beat. busy drops during the cycle of the final texel,
//  so blocks follow one another with no gap. Each result passes the first-stage and
//  result registers after its texel is walked. Reset gives format BC1, signed channels
//  with BC1 transparency, and a 16384 x 16384 image. The receiver cannot stall.
module bcn_texture_block_decode
  import bcn_tbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [13:0] block_x_i,
  input  logic [13:0] block_y_i,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  output logic        texel_strobe_o,
  output logic [1:0]  texel_col_o,
  output logic [1:0]  texel_row_o,
  output logic [7:0]  out_byte0_o,
  output logic [7:0]  out_byte1_o,
  output logic [7:0]  out_byte2_o,
  output logic [7:0]  out_byte3_o,
  output logic [3:0]  write_mask_o,
  output logic        last_o
);

  // Configuration registers.
  logic [2:0]  format_q;
  logic        no_alpha_q;
  logic [14:0] image_width_q;
  logic [14:0] image_height_q;

  // Held block and texel walker.
  logic [63:0] held_low_q, held_high_q;
  logic        run_q, run_d;
  logic [1:0]  col_q, col_d, row_q, row_d;
  logic [1:0]  last_col_q, last_col_d, last_row_q, last_row_d;
  logic        empty_q, empty_d;
  logic [3:0]  mask_q, mask_d;

  // First stage: numerators ahead of the divide.
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_col_q, s1_col_d, s1_row_q, s1_row_d;
  logic [3:0]  s1_mask_q, s1_mask_d;
  logic        s1_last_q, s1_last_d;
  px_t         s1_px_q, s1_px_d;

  // Result register.
  logic        out_valid_q;
  logic [1:0]  out_col_q, out_row_q;
  logic [7:0]  out_b0_q, out_b1_q, out_b2_q, out_b3_q;
  logic [3:0]  out_mask_q;
  logic        out_last_q;

  logic                 accept;
  logic                 at_end;
  logic [3:0]           col_ok, row_ok;
  logic [ClipW-1:0]     w_lim, h_lim;
  logic [3:0]           k;
  logic                 sgn;
  px_t                  col_px;

  // Configuration writes; the stages read these live, so write only while idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q       <= FmtBc1;
      no_alpha_q     <= 1'b0;
      image_width_q  <= 15'd16384;
      image_height_q <= 15'd16384;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgFormat:  format_q       <= cfg_data_i[2:0];
        CfgNoAlpha: no_alpha_q     <= cfg_data_i[0];
        CfgWidth:   image_width_q  <= cfg_data_i;
        CfgHeight:  image_height_q <= cfg_data_i;
        default:    format_q       <= format_q;
      endcase
    end
  end

  // Clip the incoming block: columns and rows inside the image form a prefix.
  always_comb begin
    w_lim = (ClipW'(image_width_q) > ClipW'(MaxImageSize)) ? ClipW'(MaxImageSize)
                                                            : ClipW'(image_width_q);
    h_lim = (ClipW'(image_height_q) > ClipW'(MaxImageSize)) ? ClipW'(MaxImageSize)
                                                             : ClipW'(image_height_q);
    for (int i = 0; i < 4; i++) begin
      col_ok[i] = (ClipW'(block_x_i) + ClipW'(i)) < w_lim;
      row_ok[i] = (ClipW'(block_y_i) + ClipW'(i)) < h_lim;
    end
    case (format_q)
      FmtBc1, FmtBc2, FmtBc3: mask_d = MaskRgba;
      FmtBc4:                 mask_d = MaskR;
      FmtBc5:                 mask_d = MaskRg;
      default:                mask_d = MaskNone;
    endcase
    last_col_d = col_ok[3] ? 2'd3 : col_ok[2] ? 2'd2 : col_ok[1] ? 2'd1 : 2'd0;
    last_row_d = row_ok[3] ? 2'd3 : row_ok[2] ? 2'd2 : row_ok[1] ? 2'd1 : 2'd0;
    empty_d    = !col_ok[0] || !row_ok[0] || (mask_d == MaskNone);
  end

  // Texel walker: visit only in-image texels, row-major, one per cycle.
  always_comb begin
    at_end = empty_q || (col_q == last_col_q && row_q == last_row_q);
    busy   = run_q && !at_end;
    accept = start && !busy;
    run_d  = run_q;
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      run_d = 1'b1;
      col_d = 2'd0;
      row_d = 2'd0;
    end else if (run_q) begin
      if (at_end) begin
        run_d = 1'b0;
      end else if (col_q == last_col_q) begin
        col_d = 2'd0;
        row_d = row_q + 2'd1;
      end else begin
        col_d = col_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      col_q <= 2'd0;
      row_q <= 2'd0;
    end else begin
      run_q <= run_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Hold the block payload and its clip summary from the accepting edge.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_low_q  <= block_low_i;
      held_high_q <= block_high_i;
      last_col_q  <= last_col_d;
      last_row_q  <= last_row_d;
      empty_q     <= empty_d;
      mask_q      <= mask_d;
    end
  end

  // First stage: pick endpoints and weights for the current texel.
  always_comb begin
    k      = {row_q, col_q};
    sgn    = !no_alpha_q;
    col_px = color_texel((format_q == FmtBc1) ? held_low_q : held_high_q, k,
                         format_q != FmtBc1, (format_q == FmtBc1) && !no_alpha_q);
    s1_px_d = '{default: num_direct(8'd0)};
    case (format_q)
      FmtBc1: s1_px_d = col_px;
      FmtBc2: begin
        s1_px_d    = col_px;
        s1_px_d[3] = num_direct({2{4'(held_low_q >> {k, 2'b00})}});
      end
      FmtBc3: begin
        s1_px_d    = col_px;
        s1_px_d[3] = chan_texel(held_low_q, k, 1'b0);
      end
      FmtBc4: s1_px_d[0] = chan_texel(held_low_q, k, sgn);
      FmtBc5: begin
        s1_px_d[0] = chan_texel(held_low_q, k, sgn);
        s1_px_d[1] = chan_texel(held_high_q, k, sgn);
      end
      default: s1_px_d = '{default: num_direct(8'd0)};
    endcase
    // An empty block carries a single blank beat.
    if (empty_q) begin
      s1_px_d = '{default: num_direct(8'd0)};
    end
    s1_valid_d = run_q;
    s1_col_d   = empty_q ? 2'd0 : col_q;
    s1_row_d   = empty_q ? 2'd0 : row_q;
    s1_mask_d  = empty_q ? MaskNone : mask_q;
    s1_last_d  = at_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_col_q  <= s1_col_d;
    s1_row_q  <= s1_row_d;
    s1_mask_q <= s1_mask_d;
    s1_last_q <= s1_last_d;
    s1_px_q   <= s1_px_d;
  end

  // Second stage: divide by the interpolation constant and register the beat.
  always_ff @(posedge clk_i) begin
    out_col_q  <= s1_col_q;
    out_row_q  <= s1_row_q;
    out_mask_q <= s1_mask_q;
    out_last_q <= s1_last_q;
    out_b0_q   <= div_out(s1_px_q[0]);
    out_b1_q   <= div_out(s1_px_q[1]);
    out_b2_q   <= div_out(s1_px_q[2]);
    out_b3_q   <= div_out(s1_px_q[3]);
  end

  assign texel_strobe_o = out_valid_q;
  assign texel_col_o    = out_col_q;
  assign texel_row_o    = out_row_q;
  assign out_byte0_o    = out_b0_q;
  assign out_byte1_o    = out_b1_q;
  assign out_byte2_o    = out_b2_q;
  assign out_byte3_o    = out_b3_q;
  assign write_mask_o   = out_mask_q;
  assign last_o         = out_last_q;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for bcn_texture_block_decode: BC1..BC5 blocks go in, texels come out.
// Depends on bcn_tbd_pkg for format codes, masks, register indexes and the image size limit.
// A built-in texel predictor checks every beat; directed blocks come first, then random ones.
module tb_top;
  import bcn_tbd_pkg::*;

  // Quiet cycles before a register write or the final verdict; covers the output pipeline.
  localparam int SettleCycles = 8;

  // Format codes the block must treat as a wholly clipped block.
  localparam logic [2:0] FmtNone = 3'd0;
  localparam logic [2:0] FmtSix  = 3'd6;
  localparam logic [2:0] FmtSeven = 3'd7;

  typedef enum logic [1:0] {
    OpBlock,
    OpCfg,
    OpDrain
  } job_op_e;

  // One queued piece of stimulus: a block, a register write, or a pause until drained.
  typedef struct {
    job_op_e     op;
    cfg_reg_e    idx;
    logic [14:0] val;
    logic [13:0] x;
    logic [13:0] y;
    logic [63:0] lo;
    logic [63:0] hi;
  } job_t;

  typedef struct packed {
    logic [1:0] col;
    logic [1:0] row;
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [7:0] out3;
    logic [3:0] mask;
    logic       last;
  } texel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_reg_e    cfg_index = CfgFormat;
  logic [14:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [13:0] block_x_i = '0;
  logic [13:0] block_y_i = '0;
  logic [63:0] block_low_i = '0;
  logic [63:0] block_high_i = '0;
  logic        texel_strobe_o;
  logic [1:0]  texel_col_o;
  logic [1:0]  texel_row_o;
  logic [7:0]  out_byte0_o;
  logic [7:0]  out_byte1_o;
  logic [7:0]  out_byte2_o;
  logic [7:0]  out_byte3_o;
  logic [3:0]  write_mask_o;
  logic        last_o;

  // Register copies seen by the texel predictor (reset values of the block).
  logic [2:0]  cfg_format = FmtBc1;
  logic        cfg_no_alpha = 1'b0;
  logic [14:0] cfg_width = 15'(MaxImageSize);
  logic [14:0] cfg_height = 15'(MaxImageSize);

  // Image size as the stimulus generator last set it, used to aim origins at the edges.
  int          gen_w = MaxImageSize;
  int          gen_h = MaxImageSize;

  job_t        jobs_q[$];
  texel_t      texels_q[$];
  int          texels_due = 0;
  int          texels_got = 0;
  int          mismatches = 0;
  int          idle_run = 0;
  int          gap_left = 0;
  int          burst_left = 1;

  always #2 clk_i = ~clk_i;

  bcn_texture_block_decode dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .start          (start),
    .busy           (busy),
    .block_x_i      (block_x_i),
    .block_y_i      (block_y_i),
    .block_low_i    (block_low_i),
    .block_high_i   (block_high_i),
    .texel_strobe_o (texel_strobe_o),
    .texel_col_o    (texel_col_o),
    .texel_row_o    (texel_row_o),
    .out_byte0_o    (out_byte0_o),
    .out_byte1_o    (out_byte1_o),
    .out_byte2_o    (out_byte2_o),
    .out_byte3_o    (out_byte3_o),
    .write_mask_o   (write_mask_o),
    .last_o         (last_o)
  );

  // ---------------------------------------------------------------------------------------
  // Texel predictor
  // ---------------------------------------------------------------------------------------

  // Widen a 565 value to three 8-bit channels by replicating the top bits.
  function automatic void rgb_of(input int v, output int c[3]);
    c[0] = ((v & 'h001F) << 3) | ((v & 'h001C) >> 2);
    c[1] = ((v & 'h07E0) >> 3) | ((v & 'h0600) >> 9);
    c[2] = ((v & 'hF800) >> 8) | ((v & 'hE000) >> 13);
  endfunction

  // Colour texel k of a colour half: bytes 0..2 colour, byte 3 alpha.
  function automatic logic [3:0][7:0] colour_texel(logic [63:0] word, int k, bit four,
                                                   bit transp);
    int              e0;
    int              e1;
    int              sel;
    int              ca[3];
    int              cb[3];
    int              v;
    bit              interp;
    logic [3:0][7:0] px;
    e0 = int'(word[15:0]);
    e1 = int'(word[31:16]);
    sel = int'((word >> (32 + 2 * k)) & 64'h3);
    rgb_of(e0, ca);
    rgb_of(e1, cb);
    interp = four || (e0 > e1);
    for (int n = 0; n < 3; n++) begin
      if (sel == 0) v = ca[n];
      else if (sel == 1) v = cb[n];
      else if (interp) v = (sel == 2) ? (2 * ca[n] + cb[n]) / 3 : (2 * cb[n] + ca[n]) / 3;
      else v = (sel == 2) ? (ca[n] + cb[n]) >> 1 : 0;
      px[n] = v[7:0];
    end
    // three-colour mode, index 3: transparent black when transparency is on
    px[3] = (!interp && sel == 3 && transp) ? 8'd0 : 8'd255;
    return px;
  endfunction

  // Interpolated single channel texel k; signed division truncates toward zero.
  function automatic logic [7:0] channel_texel(logic [63:0] word, int k, bit sgn);
    int a;
    int b;
    int s;
    int v;
    a = int'(word[7:0]);
    b = int'(word[15:8]);
    s = int'((word >> (16 + 3 * k)) & 64'h7);
    if (sgn) begin
      if (a > 127) a -= 256;
      if (b > 127) b -= 256;
    end
    if (s == 0) v = a;
    else if (s == 1) v = b;
    else if (a > b) v = ((8 - s) * a + (s - 1) * b) / 7;
    else if (s < 6) v = ((6 - s) * a + (s - 1) * b) / 5;
    else if (s == 6) v = sgn ? -128 : 0;
    else v = sgn ? 127 : 255;
    return v[7:0];
  endfunction

  // Queue the texels of one accepted block; return how many beats it will give.
  function automatic int decode_block(logic [13:0] x, logic [13:0] y, logic [63:0] lo,
                                      logic [63:0] hi);
    int              w;
    int              h;
    int              n;
    int              k;
    bit              sgn;
    logic [3:0]      mask;
    logic [3:0][7:0] px;
    texel_t          t;
    w = (cfg_width > MaxImageSize) ? MaxImageSize : int'(cfg_width);
    h = (cfg_height > MaxImageSize) ? MaxImageSize : int'(cfg_height);
    sgn = !cfg_no_alpha;
    n = 0;
    case (cfg_format)
      FmtBc1, FmtBc2, FmtBc3: mask = MaskRgba;
      FmtBc4:                 mask = MaskR;
      FmtBc5:                 mask = MaskRg;
      default:                mask = MaskNone;
    endcase
    for (int j = 0; j < 4 && mask != MaskNone; j++) begin
      for (int i = 0; i < 4; i++) begin
        k = j * 4 + i;
        px = '0;
        // drop texels beyond the right or bottom edge
        if (int'(x) + i >= w || int'(y) + j >= h) continue;
        case (cfg_format)
          FmtBc1: px = colour_texel(lo, k, 1'b0, !cfg_no_alpha);
          FmtBc2: begin
            px = colour_texel(hi, k, 1'b1, 1'b0);
            px[3] = {2{lo[4 * k +: 4]}};
          end
          FmtBc3: begin
            px = colour_texel(hi, k, 1'b1, 1'b0);
            px[3] = channel_texel(lo, k, 1'b0);
          end
          FmtBc4: px[0] = channel_texel(lo, k, sgn);
          default: begin
            px[0] = channel_texel(lo, k, sgn);
            px[1] = channel_texel(hi, k, sgn);
          end
        endcase
        t = '{col: 2'(i), row: 2'(j), out0: px[0], out1: px[1], out2: px[2], out3: px[3],
              mask: mask, last: 1'b0};
        texels_q.push_back(t);
        n++;
      end
    end
    // a wholly clipped block still gives one empty beat
    if (n == 0) begin
      texels_q.push_back('0);
      n = 1;
    end
    texels_q[texels_q.size() - 1].last = 1'b1;
    return n;
  endfunction

  function automatic string texel_str(texel_t t);
    return $sformatf("col %0d row %0d bytes %h %h %h %h mask %h last %b",
                     t.col, t.row, t.out0, t.out1, t.out2, t.out3, t.mask, t.last);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: raise start in bursts, hold it until the beat is taken, and write registers
  // only once the block has drained and settled.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_blocks
    job_t job;
    logic start_nxt;
    logic we_nxt;
    logic quiet;
    if (rst_ni) begin
      start_nxt = start;
      we_nxt = 1'b0;
      quiet = (texels_due == texels_got) && !start;
      if (start && !busy) begin
        texels_due <= texels_due + decode_block(block_x_i, block_y_i, block_low_i,
                                                block_high_i);
        start_nxt = 1'b0;
      end
      idle_run <= quiet ? idle_run + 1 : 0;
      if (!start_nxt && jobs_q.size() != 0) begin
        if (jobs_q[0].op == OpBlock) begin
          if (gap_left != 0) begin
            gap_left <= gap_left - 1;
          end else begin
            job = jobs_q.pop_front();
            block_x_i <= job.x;
            block_y_i <= job.y;
            block_low_i <= job.lo;
            block_high_i <= job.hi;
            start_nxt = 1'b1;
            if (burst_left > 1) begin
              burst_left <= burst_left - 1;
            end else begin
              // pick the next burst and the gap that follows it
              case ($urandom_range(0, 9))
                0, 1, 2: begin
                  burst_left <= $urandom_range(1, 8);
                  gap_left <= 0;
                end
                3, 4, 5, 6: begin
                  burst_left <= $urandom_range(1, 6);
                  gap_left <= $urandom_range(1, 7);
                end
                7, 8: begin
                  burst_left <= $urandom_range(1, 4);
                  gap_left <= $urandom_range(10, 30);
                end
                default: begin
                  burst_left <= $urandom_range(20, 40);
                  gap_left <= 0;
                end
              endcase
            end
          end
        end else if (quiet && idle_run >= SettleCycles) begin
          job = jobs_q.pop_front();
          if (job.op == OpCfg) begin
            we_nxt = 1'b1;
            cfg_index <= job.idx;
            cfg_data <= job.val;
            case (job.idx)
              CfgFormat:  cfg_format = job.val[2:0];
              CfgNoAlpha: cfg_no_alpha = job.val[0];
              CfgWidth:   cfg_width = job.val;
              default:    cfg_height = job.val;
            endcase
          end
        end
      end
      start <= start_nxt;
      cfg_we <= we_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: every strobed beat must match the oldest predicted texel.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_texels
    texel_t got;
    texel_t want;
    if (rst_ni && texel_strobe_o) begin
      got = '{col: texel_col_o, row: texel_row_o, out0: out_byte0_o, out1: out_byte1_o,
              out2: out_byte2_o, out3: out_byte3_o, mask: write_mask_o, last: last_o};
      if (texels_q.size() == 0) begin
        $display("%0t: unexpected texel, got %s", $time, texel_str(got));
        mismatches++;
      end else begin
        want = texels_q.pop_front();
        texels_got <= texels_got + 1;
        if (got !== want) begin
          $display("%0t: texel mismatch, expected %s, got %s", $time, texel_str(want),
                   texel_str(got));
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------
  task automatic put_cfg(cfg_reg_e idx, logic [14:0] val);
    job_t job;
    job = '{op: OpCfg, idx: idx, val: val, x: '0, y: '0, lo: '0, hi: '0};
    jobs_q.push_back(job);
    if (idx == CfgWidth) gen_w = (val > MaxImageSize) ? MaxImageSize : int'(val);
    if (idx == CfgHeight) gen_h = (val > MaxImageSize) ? MaxImageSize : int'(val);
  endtask

  task automatic put_block(logic [13:0] x, logic [13:0] y, logic [63:0] lo, logic [63:0] hi);
    job_t job;
    job = '{op: OpBlock, idx: CfgFormat, val: '0, x: x, y: y, lo: lo, hi: hi};
    jobs_q.push_back(job);
  endtask

  // Hold the sender until every predicted texel has come out.
  task automatic put_drain();
    job_t job;
    job = '{op: OpDrain, idx: CfgFormat, val: '0, x: '0, y: '0, lo: '0, hi: '0};
    jobs_q.push_back(job);
  endtask

  // Endpoints a, b and selectors walking 0..7 across the sixteen texels.
  function automatic logic [63:0] chan_word(logic [7:0] a, logic [7:0] b);
    logic [63:0] w;
    w = {48'h0, b, a};
    for (int k = 0; k < 16; k++) w[16 + 3 * k +: 3] = 3'(k % 8);
    return w;
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: w[31:16] = w[15:0];
      1: w[15:8] = w[7:0];
      default: ;
    endcase
    return w;
  endfunction

  // Aim origins across the image, just inside its edge or at the far end, so clipping is exercised.
  function automatic logic [13:0] pick_origin(int lim);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(0, (lim + 3) / 4) * 4;
      6, 7:             v = lim - $urandom_range(1, 6);
      8:                v = $urandom_range(0, 16383);
      default:          v = 16380 + $urandom_range(0, 3);
    endcase
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return v[13:0];
  endfunction

  function automatic logic [14:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 15'(MaxImageSize);
      1:       return 15'h7FFF;
      2:       return 15'd1;
      3:       return 15'($urandom_range(0, 32767));
      4:       return 15'd0;
      default: return 15'($urandom_range(1, 64));
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus, reset and verdict
  // ---------------------------------------------------------------------------------------
  initial begin : run_test
    logic [2:0] fmt;

    // BC1 from reset: four-colour, three-colour with transparency, equal endpoints
    put_block(14'd0, 14'd0, {32'hE4E4_E4E4, 16'h001F, 16'hF800}, 64'h0);
    put_block(14'd4, 14'd0, {32'hE4E4_E4E4, 16'hF800, 16'h001F}, 64'h0);
    put_block(14'd8, 14'd0, {32'hFFFF_FFFF, 16'h7BEF, 16'h7BEF}, 64'h0);
    put_block(14'd0, 14'd4, 64'h0, 64'h0);
    put_block(14'd0, 14'd8, '1, '1);
    put_block(14'd16380, 14'd16380, 64'h1B1B_E4E4_07E0_FFE0, 64'h0);
    // unaligned origin at the far corner: only one texel survives
    put_block(14'd16383, 14'd16383, 64'h5555_AAAA_1234_4321, 64'h0);
    // transparency off: index 3 in three-colour mode becomes opaque black
    put_cfg(CfgNoAlpha, 15'd1);
    put_block(14'd0, 14'd0, {32'hE4E4_E4E4, 16'hF800, 16'h001F}, 64'h0);
    // tiny image: partial and whole clipping
    put_cfg(CfgWidth, 15'd6);
    put_cfg(CfgHeight, 15'd5);
    put_block(14'd4, 14'd4, 64'hA5A5_5A5A_F81F_07E0, 64'h0);
    put_block(14'd8, 14'd0, 64'hA5A5_5A5A_F81F_07E0, 64'h0);
    put_block(14'd0, 14'd0, 64'h0F0F_F0F0_001F_F800, 64'h0);
    put_cfg(CfgWidth, 15'(MaxImageSize));
    put_cfg(CfgHeight, 15'(MaxImageSize));
    // BC2: explicit alpha, colour forced to four-colour mode
    put_cfg(CfgFormat, 15'(FmtBc2));
    put_block(14'd0, 14'd0, 64'hFEDC_BA98_7654_3210, {32'hE4E4_E4E4, 16'hF800, 16'h001F});
    put_block(14'd12, 14'd40, {$urandom, $urandom}, {$urandom, $urandom});
    // BC3: both alpha interpolation modes
    put_cfg(CfgFormat, 15'(FmtBc3));
    put_block(14'd0, 14'd0, chan_word(8'h10, 8'hF0), {32'h1B1B_E4E4, 16'h07E0, 16'hF81F});
    put_block(14'd4, 14'd0, chan_word(8'hF0, 8'h10), {32'hE4E4_1B1B, 16'hFFFF, 16'h0000});
    // BC4 signed: extremes, and negative results truncating toward zero
    put_cfg(CfgFormat, 15'(FmtBc4));
    put_cfg(CfgNoAlpha, 15'd0);
    put_block(14'd0, 14'd0, chan_word(8'h80, 8'h7F), 64'h0);
    put_block(14'd0, 14'd4, chan_word(8'h7F, 8'h80), 64'h0);
    put_block(14'd0, 14'd8, chan_word(8'h05, 8'hFB), 64'h0);
    // BC4 unsigned
    put_cfg(CfgNoAlpha, 15'd1);
    put_block(14'd0, 14'd0, chan_word(8'h80, 8'h7F), 64'h0);
    put_block(14'd4, 14'd0, chan_word(8'h00, 8'hFF), 64'h0);
    // BC5 unsigned then signed
    put_cfg(CfgFormat, 15'(FmtBc5));
    put_block(14'd0, 14'd0, chan_word(8'h81, 8'h7F), chan_word(8'h7F, 8'h81));
    put_cfg(CfgNoAlpha, 15'd0);
    put_block(14'd0, 14'd0, chan_word(8'h81, 8'h7F), chan_word(8'hFB, 8'h05));
    // formats outside BC1..BC5 give one empty beat
    put_cfg(CfgFormat, 15'(FmtNone));
    put_block(14'd0, 14'd0, '1, '1);
    put_cfg(CfgFormat, 15'(FmtSeven));
    put_block(14'd0, 14'd0, '1, '1);
    // zero width clips everything; an oversized width saturates
    put_cfg(CfgFormat, 15'(FmtBc1));
    put_cfg(CfgWidth, 15'd0);
    put_block(14'd0, 14'd0, 64'h1234_5678_9ABC_DEF0, 64'h0);
    put_cfg(CfgWidth, 15'h7FFF);
    put_block(14'd16380, 14'd0, 64'h1234_5678_9ABC_DEF0, 64'h0);

    // random phases: new settings, then blocks with random content near the edges
    for (int p = 0; p < 13; p++) begin
      case ($urandom_range(0, 11))
        0, 1:    fmt = FmtBc1;
        2, 3:    fmt = FmtBc2;
        4, 5:    fmt = FmtBc3;
        6, 7:    fmt = FmtBc4;
        8, 9:    fmt = FmtBc5;
        10:      fmt = FmtSix;
        default: fmt = ($urandom_range(0, 1) != 0) ? FmtNone : FmtSeven;
      endcase
      put_cfg(CfgFormat, 15'(fmt));
      put_cfg(CfgNoAlpha, 15'($urandom_range(0, 1)));
      put_cfg(CfgWidth, pick_size());
      put_cfg(CfgHeight, pick_size());
      for (int n = 0; n < 26; n++) begin
        put_block(pick_origin(gen_w), pick_origin(gen_h), rand_word(), rand_word());
        // now and then let the pipeline run dry mid-phase
        if (n == 12 && (p == 0 || $urandom_range(0, 2) == 0)) put_drain();
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // wait for the last beat, then give stray results time to show up
    while (jobs_q.size() != 0 || start || texels_due != texels_got) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && texels_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("%0t: timeout, %0d texel beats still outstanding", $time,
             texels_due - texels_got);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ bcn_texture_block_decode.f @@
src/bcn_tbd_pkg.sv
src/bcn_texture_block_decode.sv
tb/sv/tb_top.sv
